### rtl/pbd_pkg.sv
package pbd_pkg;

  localparam int unsigned NumChannelsDef = 8;
  localparam int unsigned WindowDepthDef = 8;

  localparam int unsigned MaskW    = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned ReadingW = 25;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumThrRegs = 4;

  localparam logic [CfgDataW-1:0] ThrReset01   = 32'd6553700;
  localparam logic [CfgDataW-1:0] ThrReset23   = 32'd58983300;
  localparam logic [CfgDataW-1:0] ThrReset45   = 32'd32768500;
  localparam logic [CfgDataW-1:0] ThrReset67   = 32'd65537000;
  localparam logic [MaskW-1:0]    PresentReset = 8'hFF;
  localparam logic [TimeW-1:0]    TimeoutReset = 32'd5000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThr01   = 3'd0,
    CfgThr23   = 3'd1,
    CfgThr45   = 3'd2,
    CfgThr67   = 3'd3,
    CfgPresent = 3'd4,
    CfgTimeout = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                       valid;
    logic [ChanW-1:0]           channel;
    logic                       has_reading;
    logic signed [ReadingW-1:0] reading;
    logic [TimeW-1:0]           time_ms;
    logic [MaskW-1:0]           active;
    logic [MaskW-1:0]           avail;
    logic                       stored;
  } pkt_t;

endpackage

### rtl/pbd_if.sv
interface pbd_evt_if;
  logic                                    valid;
  logic                                    ready;
  logic [pbd_pkg::ChanW-1:0]               channel;
  logic                                    has_reading;
  logic signed [pbd_pkg::ReadingW-1:0]     reading;
  logic [pbd_pkg::TimeW-1:0]               time_ms;

  modport source (output valid, channel, has_reading, reading, time_ms, input ready);
  modport sink   (input valid, channel, has_reading, reading, time_ms, output ready);
endinterface

interface pbd_res_if;
  logic                        valid;
  logic                        ready;
  logic [pbd_pkg::MaskW-1:0]   active_mask;
  logic [pbd_pkg::MaskW-1:0]   rising_mask;
  logic [pbd_pkg::MaskW-1:0]   available_mask;
  logic [pbd_pkg::CountW-1:0]  available_count;
  logic                        sample_stored;

  modport source (output valid, active_mask, rising_mask, available_mask,
                  available_count, sample_stored, input ready);
  modport sink   (input valid, active_mask, rising_mask, available_mask,
                  available_count, sample_stored, output ready);
endinterface

### rtl/pbd_cell.sv
module pbd_cell #(
  parameter int unsigned CH_IDX       = 0,
  parameter int unsigned WINDOW_DEPTH = pbd_pkg::WindowDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [pbd_pkg::ThrW-1:0]    thr_i,
  input  logic                        present_i,
  input  logic [pbd_pkg::TimeW-1:0]   timeout_i,
  input  pbd_pkg::pkt_t               pkt_i,
  output pbd_pkg::pkt_t               pkt_o
);
  import pbd_pkg::*;

  localparam logic [ChanW-1:0] ChIdx = ChanW'(CH_IDX);

  logic signed [ReadingW-1:0] win_q [WINDOW_DEPTH];
  logic signed [ReadingW-1:0] win_d [WINDOW_DEPTH];
  logic                       fv_q, fv_d;
  logic [TimeW-1:0]           start_q, start_d;
  logic                       lost_q, lost_d;
  pkt_t                       pkt_q, pkt_d;

  logic                       hit, fail, store;
  logic [TimeW-1:0]           elapsed;
  logic signed [ReadingW:0]   diff;
  logic                       act;

  always_comb begin
    hit     = adv_i && pkt_i.valid && (pkt_i.channel == ChIdx) && present_i && !lost_q;
    fail    = !pkt_i.has_reading || pkt_i.reading[ReadingW-1];
    store   = hit && pkt_i.has_reading && (pkt_i.reading != '0);
    elapsed = pkt_i.time_ms - start_q;

    fv_d    = fv_q;
    start_d = start_q;
    lost_d  = lost_q;
    if (hit && fail) begin
      if (!fv_q) begin
        fv_d    = 1'b1;
        start_d = pkt_i.time_ms;
      end else if (elapsed > timeout_i) begin
        lost_d = 1'b1;
      end
    end else if (hit) begin
      fv_d    = 1'b0;
      start_d = '0;
    end

    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_d[i] = win_q[i];
    end
    if (store) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WINDOW_DEPTH-1] = pkt_i.reading;
    end

    diff = {win_d[WINDOW_DEPTH-1][ReadingW-1], win_d[WINDOW_DEPTH-1]}
         - {win_d[0][ReadingW-1], win_d[0]};
    act  = diff > $signed({{(ReadingW+1-ThrW){1'b0}}, thr_i});

    pkt_d                = pkt_i;
    pkt_d.active[CH_IDX] = act;
    pkt_d.avail[CH_IDX]  = present_i && !lost_d;
    pkt_d.stored         = pkt_i.stored || store;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      fv_q    <= 1'b0;
      start_q <= '0;
      lost_q  <= 1'b0;
      pkt_q   <= '0;
    end else begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= win_d[i];
      end
      fv_q    <= fv_d;
      start_q <= start_d;
      lost_q  <= lost_d;
      if (adv_i) begin
        pkt_q <= pkt_d;
      end
    end
  end

  assign pkt_o = pkt_q;

endmodule

### rtl/pressure_bumper_detector.sv
// Channel  Dir  Handshake          Payload
// evt_i    in   valid/ready        channel, has_reading, reading, time_ms
// res_o    out  valid/ready        active_mask, rising_mask, available_mask,
//                                  available_count, sample_stored
// cfg      in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One event per cycle unless the output stalls; each event passes in turn
// through the registered cell of every channel and leaves the last as a result.
// Reset clears every sample window, offline timer and lost flag at once.
// A result not taken stalls the whole chain; evt_i.ready drops only then.
module pressure_bumper_detector #(
  parameter int unsigned NUM_CHANNELS = pbd_pkg::NumChannelsDef,
  parameter int unsigned WINDOW_DEPTH = pbd_pkg::WindowDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pbd_evt_if.sink                       evt_i,
  pbd_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [pbd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pbd_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pbd_pkg::*;

  localparam logic [MaskW-1:0] ChanMask = MaskW'((1 << NUM_CHANNELS) - 1);

  logic [CfgDataW-1:0] thr_q [NumThrRegs];
  logic [MaskW-1:0]    present_q;
  logic [TimeW-1:0]    timeout_q;
  logic [MaskW-1:0]    prev_act_q;

  pkt_t                pkt [NUM_CHANNELS+1];
  logic                adv;
  logic [CountW-1:0]   count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q[0]  <= ThrReset01;
      thr_q[1]  <= ThrReset23;
      thr_q[2]  <= ThrReset45;
      thr_q[3]  <= ThrReset67;
      present_q <= PresentReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgThr01, CfgThr23, CfgThr45, CfgThr67: thr_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        CfgPresent: present_q <= cfg_wdata_i[MaskW-1:0];
        CfgTimeout: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv = !pkt[NUM_CHANNELS].valid || res_o.ready;
  assign evt_i.ready = adv;

  always_comb begin
    pkt[0]             = '0;
    pkt[0].valid       = evt_i.valid;
    pkt[0].channel     = evt_i.channel;
    pkt[0].has_reading = evt_i.has_reading;
    pkt[0].reading     = evt_i.reading;
    pkt[0].time_ms     = evt_i.time_ms;
  end

  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_cell
    pbd_cell #(
      .CH_IDX       (k),
      .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .thr_i     (thr_q[k/2][(k%2)*ThrW +: ThrW]),
      .present_i (present_q[k]),
      .timeout_i (timeout_q),
      .pkt_i     (pkt[k]),
      .pkt_o     (pkt[k+1])
    );
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < MaskW; i++) begin
      count = count + CountW'(pkt[NUM_CHANNELS].avail[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_act_q <= '0;
    end else if (res_o.valid && res_o.ready) begin
      prev_act_q <= pkt[NUM_CHANNELS].active;
    end
  end

  assign res_o.valid           = pkt[NUM_CHANNELS].valid;
  assign res_o.active_mask     = pkt[NUM_CHANNELS].active;
  assign res_o.rising_mask     = pkt[NUM_CHANNELS].active & ~prev_act_q;
  assign res_o.available_mask  = pkt[NUM_CHANNELS].avail;
  assign res_o.available_count = count;
  assign res_o.sample_stored   = pkt[NUM_CHANNELS].stored;

`ifndef NO_ASSERTIONS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.available_count == CountW'($countones(res_o.available_mask)))
    else $error("available_count disagrees with available_mask");

  a_rising_in_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.rising_mask & ~res_o.active_mask) == '0)
    else $error("rising bit without active bit");

  a_no_extra_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.active_mask | res_o.available_mask) & ~ChanMask) == '0)
    else $error("mask bit set above the channel count");

  a_avail_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.available_mask & ~present_q) == '0)
    else $error("available channel not present");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !evt_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input stalled without output backpressure");
`endif

endmodule
